// ===== sv/lzwe_pkg.sv =====
package lzwe_pkg;

  localparam int CODE_BITS   = 13;
  localparam int MAX_STRING  = 256;
  localparam int DICT_SIZE   = 1 << CODE_BITS;
  localparam int FIRST_CODE  = 256;
  localparam int LEN_W       = 9;
  localparam int FREE_W      = CODE_BITS + 1;
  localparam int KEY_W       = CODE_BITS + 8;
  localparam int TABLE_BITS  = CODE_BITS + 1;
  localparam int TABLE_DEPTH = 1 << TABLE_BITS;
  localparam int EPOCH_W     = 8;
  localparam int ENTRY_W     = 1 + EPOCH_W + KEY_W + CODE_BITS;
  localparam int ACC_W       = CODE_BITS + 8;
  localparam int CNT_W       = 5;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_PROBE,
    ST_CHECK,
    ST_DRAIN,
    ST_TAIL,
    ST_FLUSH,
    ST_END
  } lzwe_state_t;

  typedef struct packed {
    logic accept;
    logic start_str;
    logic emit;
    logic probe_start;
    logic probe_next;
    logic take_match;
    logic insert;
    logic out_load;
    logic flush;
    logic end_msg;
    logic clear_step;
  } lzwe_cmd_t;

  typedef struct packed {
    logic started;
    logic len_cap;
    logic hit;
    logic empty;
    logic cnt_ge8;
    logic cnt_nz;
    logic slot_free;
    logic last;
    logic clear_done;
    logic epoch_wrap;
  } lzwe_status_t;

endpackage

// ===== sv/lzwe_ctrl.sv =====
module lzwe_ctrl import lzwe_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  lzwe_status_t status,
  output lzwe_cmd_t    cmd
);

  lzwe_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!status.started) begin
          cmd.start_str = 1'b1;
          state_next    = ST_TAIL;
        end else if (status.len_cap) begin
          cmd.emit      = 1'b1;
          cmd.start_str = 1'b1;
          state_next    = ST_DRAIN;
        end else begin
          cmd.probe_start = 1'b1;
          state_next      = ST_PROBE;
        end
      end
      ST_PROBE: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.hit) begin
          cmd.take_match = 1'b1;
          state_next     = ST_TAIL;
        end else if (status.empty) begin
          cmd.emit      = 1'b1;
          cmd.insert    = 1'b1;
          cmd.start_str = 1'b1;
          state_next    = ST_DRAIN;
        end else begin
          cmd.probe_next = 1'b1;
          state_next     = ST_PROBE;
        end
      end
      ST_DRAIN: begin
        if (status.cnt_ge8) begin
          if (status.slot_free) cmd.out_load = 1'b1;
        end else begin
          state_next = ST_TAIL;
        end
      end
      ST_TAIL: begin
        if (status.last) begin
          cmd.emit   = 1'b1;
          state_next = ST_FLUSH;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        if (status.cnt_nz) begin
          if (status.slot_free) cmd.out_load = 1'b1;
        end else begin
          state_next = ST_END;
        end
      end
      ST_END: begin
        cmd.end_msg = 1'b1;
        state_next  = status.epoch_wrap ? ST_CLEAR : ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== sv/lzwe_dp.sv =====
module lzwe_dp import lzwe_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic [7:0]   data_byte,
  input  logic         end_of_message,
  input  logic         out_stall,
  output logic [7:0]   packed_byte,
  output logic         final_byte,
  output logic         out_valid,
  input  lzwe_cmd_t    cmd,
  output lzwe_status_t status
);

  logic [7:0]             in_byte;
  logic                   in_last;
  logic [CODE_BITS-1:0]   cur_code;
  logic [LEN_W-1:0]       cur_len;
  logic                   started;
  logic [FREE_W-1:0]      next_free;
  logic [EPOCH_W-1:0]     epoch;
  logic [TABLE_BITS-1:0]  probe_addr;
  logic [TABLE_BITS-1:0]  clr_cnt;
  logic [ACC_W-1:0]       acc;
  logic [CNT_W-1:0]       cnt;
  logic [ENTRY_W-1:0]     mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0]     rdata;

  logic [KEY_W-1:0]       key;
  logic [TABLE_BITS-1:0]  hash;
  logic                   r_valid;
  logic [EPOCH_W-1:0]     r_epoch;
  logic [KEY_W-1:0]       r_key;
  logic [CODE_BITS-1:0]   r_code;
  logic                   live;
  logic                   full;
  logic                   we;
  logic [TABLE_BITS-1:0]  waddr;
  logic [ENTRY_W-1:0]     wdata;
  logic [ACC_W-1:0]       shifted;
  logic [7:0]             pad_byte;
  logic [7:0]             byte_sel;
  logic                   slot_free;

  assign key  = {cur_code, in_byte};
  assign hash = {in_byte, {(TABLE_BITS-8){1'b0}}} ^ {1'b0, cur_code};

  assign {r_valid, r_epoch, r_key, r_code} = rdata;
  assign live = r_valid && (r_epoch == epoch);
  assign full = next_free[FREE_W-1];

  // Each new entry goes into the first empty slot that its probe found.
  assign we    = cmd.clear_step || (cmd.insert && !full);
  assign waddr = cmd.clear_step ? clr_cnt : probe_addr;
  assign wdata = cmd.clear_step ? '0
               : {1'b1, epoch, key, next_free[CODE_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[probe_addr];
  end

  assign shifted   = acc >> (cnt - CNT_W'(8));
  assign pad_byte  = 8'(acc[7:0] << (CNT_W'(8) - cnt));
  assign byte_sel  = (cnt >= CNT_W'(8)) ? shifted[7:0] : pad_byte;
  assign slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_byte <= data_byte;
      in_last <= end_of_message;
    end
    if (cmd.probe_start) probe_addr <= hash;
    else if (cmd.probe_next) probe_addr <= probe_addr + 1'b1;
    if (cmd.out_load) begin
      packed_byte <= byte_sel;
      final_byte  <= cmd.flush && (cnt <= CNT_W'(8));
    end
    if (cmd.emit) acc <= {acc[7:0], cur_code};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_code  <= '0;
      cur_len   <= '0;
      started   <= 1'b0;
      next_free <= FREE_W'(FIRST_CODE);
      epoch     <= '0;
      clr_cnt   <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear_step) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.end_msg) begin
        cur_code  <= '0;
        cur_len   <= '0;
        started   <= 1'b0;
        next_free <= FREE_W'(FIRST_CODE);
        epoch     <= epoch + 1'b1;
        cnt       <= '0;
      end else begin
        if (cmd.start_str) begin
          cur_code <= CODE_BITS'(in_byte);
          cur_len  <= LEN_W'(1);
          started  <= 1'b1;
        end else if (cmd.take_match) begin
          cur_code <= r_code;
          cur_len  <= cur_len + 1'b1;
        end
        if (cmd.insert && !full) next_free <= next_free + 1'b1;
        if (cmd.emit) begin
          cnt <= cnt + CNT_W'(CODE_BITS);
        end else if (cmd.out_load) begin
          cnt <= (cnt >= CNT_W'(8)) ? cnt - CNT_W'(8) : '0;
        end
      end
    end
  end

  assign status.started    = started;
  assign status.len_cap    = cur_len >= LEN_W'(MAX_STRING);
  assign status.hit        = live && (r_key == key);
  assign status.empty      = !live;
  assign status.cnt_ge8    = cnt >= CNT_W'(8);
  assign status.cnt_nz     = cnt != '0;
  assign status.slot_free  = slot_free;
  assign status.last       = in_last;
  assign status.clear_done = &clr_cnt;
  assign status.epoch_wrap = &epoch;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(ACC_W - 1))
    else $error("bit count overflow");

  a_emit_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> cnt < CNT_W'(8))
    else $error("code pushed before previous bits were drained");

  a_insert_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> !live)
    else $error("insert over a live table slot");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> slot_free)
    else $error("output register overwritten");

endmodule

// ===== sv/lzw_encoder_fixed_code_top.sv =====
// LZW encoder with fixed 13-bit codes, packed MSB-first into bytes.
// Input channel: data_byte with end_of_message, handshake in_valid/in_stall.
// Output channel: packed_byte with final_byte, handshake out_valid/out_stall.
// An item is taken when valid is high and stall is low on that channel.
// One input item is handled at a time. The dictionary is a 16384-slot hash
// table with linear probing in a memory with one write and one read port;
// each probe is a read step followed by a compare step. A byte that ends a
// string also drains the output bytes of its code, and an end of message
// also flushes the final code and pad, so an item yields 0 to 5 output
// bytes.
// Table slots carry a message tag, so a new message starts with an empty
// dictionary at no cost. After reset, and after every 256th message, a
// clearing pass over all 16384 slots runs while in_stall is held high.
// Output bytes sit in one output register; while out_stall is high the
// encoder holds any next byte, and while it holds one it takes no new input.
module lzw_encoder_fixed_code_top import lzwe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] packed_byte,
  output logic       final_byte
);

  lzwe_cmd_t    cmd;
  lzwe_status_t status;

  lzwe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lzwe_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .out_stall      (out_stall),
    .packed_byte    (packed_byte),
    .final_byte     (final_byte),
    .out_valid      (out_valid),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top import lzwe_pkg::*; ();

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] data_byte;
  logic       end_of_message;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] packed_byte;
  logic       final_byte;

  lzw_encoder_fixed_code_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .end_of_message(end_of_message),
    .out_valid(out_valid), .out_stall(out_stall),
    .packed_byte(packed_byte), .final_byte(final_byte)
  );

  typedef struct {
    logic [7:0] pbyte;
    logic       fin;
  } out_byte_t;

  // Directed row: n_typed < 0 means the predictor supplies the bytes.
  typedef struct {
    logic [7:0] dbyte;
    logic       eom;
    int         n_typed;
    logic [7:0] t0;
    logic [7:0] t1;
  } dir_row_t;

  out_byte_t pending_out_q[$];
  int        n_errors;
  bit        quiet;
  int        idle_cycles;

  // Encoder state mirror.
  int               code_of[int];
  int unsigned      enc_next_free;
  logic [12:0]      enc_cur;
  int               enc_len;
  bit               enc_started;
  logic [6:0]       enc_pbits;
  int               enc_pcnt;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  task automatic report(input string what);
    n_errors++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic clear_encoder();
    code_of.delete();
    enc_next_free = FIRST_CODE;
    enc_cur = '0;
    enc_len = 0;
    enc_started = 0;
    enc_pbits = '0;
    enc_pcnt = 0;
  endtask

  task automatic pack_code(input logic [12:0] code);
    logic [19:0] acc;
    int bits;
    out_byte_t ob;
    acc = {enc_pbits, code};
    bits = enc_pcnt + CODE_BITS;
    while (bits >= 8) begin
      bits -= 8;
      ob.pbyte = 8'(acc >> bits);
      ob.fin = 0;
      pending_out_q.push_back(ob);
    end
    enc_pcnt = bits;
    enc_pbits = 7'(acc & ((20'd1 << bits) - 1));
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic last);
    int key;
    out_byte_t ob;
    if (!enc_started) begin
      enc_cur = b;
      enc_len = 1;
      enc_started = 1;
    end else if (enc_len >= MAX_STRING) begin
      pack_code(enc_cur);
      enc_cur = b;
      enc_len = 1;
    end else begin
      key = {enc_cur, b};
      if (code_of.exists(key)) begin
        enc_cur = 13'(code_of[key]);
        enc_len++;
      end else begin
        pack_code(enc_cur);
        if (enc_next_free < DICT_SIZE) begin
          code_of[key] = enc_next_free;
          enc_next_free++;
        end
        enc_cur = b;
        enc_len = 1;
      end
    end
    if (last) begin
      pack_code(enc_cur);
      if (enc_pcnt > 0) begin
        ob.pbyte = 8'({1'b0, enc_pbits} << (8 - enc_pcnt));
        ob.fin = 0;
        pending_out_q.push_back(ob);
      end
      pending_out_q[$].fin = 1;
      clear_encoder();
    end
  endtask

  // Sends one item; typed expectations replace the predicted ones.
  task automatic send_item(input logic [7:0] b, input logic e, input int n_typed,
                           input logic [7:0] t0, input logic [7:0] t1);
    int gap;
    int base;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    data_byte <= b;
    end_of_message <= e;
    do @(posedge clk); while (in_stall);
    base = pending_out_q.size();
    encode_byte(b, e);
    if (n_typed >= 0) begin
      if (pending_out_q.size() - base != n_typed)
        report("typed row disagrees with predicted byte count");
      while (pending_out_q.size() > base) void'(pending_out_q.pop_back());
      if (n_typed > 0) pending_out_q.push_back('{t0, 0});
      if (n_typed > 1) pending_out_q.push_back('{t1, 1});
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic e);
    send_item(b, e, -1, 8'h00, 8'h00);
  endtask

  // Output side: random stall per byte, checked against the oldest expectation.
  initial begin
    int cnt;
    out_byte_t ob;
    out_stall = 1;
    cnt = 3;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (pending_out_q.size() == 0) begin
          report($sformatf("unexpected byte %02h", packed_byte));
        end else begin
          ob = pending_out_q.pop_front();
          if (packed_byte !== ob.pbyte)
            report($sformatf("packed_byte %02h, wanted %02h", packed_byte, ob.pbyte));
          if (final_byte !== ob.fin)
            report($sformatf("final_byte %0b, wanted %0b", final_byte, ob.fin));
        end
        cnt = quiet ? 0 : $urandom_range(0, 14);
        out_stall <= (cnt > 0);
      end else if (cnt > 0) begin
        cnt--;
        if (cnt == 0) out_stall <= 0;
      end
    end
  end

  // Watchdog on cycles without any accepted item.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 80000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  dir_row_t dir_rows[] = '{
    '{8'h00, 1'b1, 2, 8'h00, 8'h00},
    '{8'hFF, 1'b1, 2, 8'h07, 8'hF8},
    '{8'h80, 1'b1, 2, 8'h04, 8'h00},
    '{8'h41, 1'b0, -1, 0, 0}, '{8'h42, 1'b1, -1, 0, 0},
    '{8'h61, 1'b0, -1, 0, 0}, '{8'h62, 1'b0, -1, 0, 0},
    '{8'h61, 1'b0, -1, 0, 0}, '{8'h62, 1'b0, -1, 0, 0},
    '{8'h61, 1'b0, -1, 0, 0}, '{8'h62, 1'b0, -1, 0, 0},
    '{8'h61, 1'b0, -1, 0, 0}, '{8'h62, 1'b1, -1, 0, 0},
    '{8'h55, 1'b0, -1, 0, 0}, '{8'h55, 1'b0, -1, 0, 0},
    '{8'h55, 1'b0, -1, 0, 0}, '{8'h55, 1'b0, -1, 0, 0},
    '{8'h55, 1'b0, -1, 0, 0}, '{8'h55, 1'b1, -1, 0, 0},
    '{8'hFF, 1'b0, -1, 0, 0}, '{8'h00, 1'b0, -1, 0, 0},
    '{8'hAA, 1'b0, -1, 0, 0}, '{8'h00, 1'b1, -1, 0, 0}
  };

  initial begin
    int len;
    int alpha;
    int n_sent;
    rst = 1;
    in_valid = 0;
    data_byte = '0;
    end_of_message = 0;
    n_errors = 0;
    quiet = 0;
    clear_encoder();
    repeat (4) @(posedge clk);
    rst <= 0;

    foreach (dir_rows[i])
      send_item(dir_rows[i].dbyte, dir_rows[i].eom, dir_rows[i].n_typed,
                dir_rows[i].t0, dir_rows[i].t1);

    // Hold the sender until the output side has drained.
    in_valid <= 0;
    while (pending_out_q.size() != 0) @(posedge clk);

    // Short messages; small alphabets make strings grow.
    n_sent = 0;
    while (n_sent < 100) begin
      len = $urandom_range(1, 12);
      alpha = $urandom_range(0, 2);
      for (int k = 0; k < len; k++)
        send_byte(alpha == 0 ? 8'($urandom_range(0, 255)) :
                  alpha == 1 ? 8'($urandom_range(8'h30, 8'h32)) :
                  8'($urandom_range(0, 1) ? 8'h00 : 8'hFF), k == len - 1);
      n_sent += len;
      if (pending_out_q.size() == 0 && $urandom_range(0, 3) == 0) quiet = ~quiet;
    end
    quiet = 0;
    for (int k = 0; k < 8; k++)
      send_byte(8'($urandom_range(0, 255)), k == 7);

    in_valid <= 0;
    while (pending_out_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== lzw_encoder_fixed_code_top.f =====
sv/lzwe_pkg.sv
sv/lzwe_ctrl.sv
sv/lzwe_dp.sv
sv/lzw_encoder_fixed_code_top.sv
verif/tb_top.sv
